### rtl/scharr_gradient_direction_macros.svh
// Assertion macros shared by the checker of the Scharr gradient block.
`ifndef SCHARR_GRADIENT_DIRECTION_MACROS_SVH
`define SCHARR_GRADIENT_DIRECTION_MACROS_SVH

// Same-cycle implication, sampled on the block clock and quiet in reset.
`define SCGD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock and quiet in reset.
`define SCGD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/scgd_pkg.sv
// Types and constants of the Scharr gradient and direction block.
`default_nettype none

package scgd_pkg;

   localparam int PIX_W         = 8;
   localparam int GRAD_W        = 13;
   localparam int MAG_W         = 17;
   localparam int DIR_W         = 16;
   localparam int CFG_WIDTH_W   = 12;
   localparam int CFG_HEIGHT_W  = 13;
   localparam int ROW_W         = 12;
   localparam int HEIGHT_CAP    = 4096;
   localparam int WIDTH_RESET   = 640;
   localparam int HEIGHT_RESET  = 480;
   localparam int CSR_IDX_W     = 4;
   localparam int CSR_DATA_W    = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 4'd1;

   // Arithmetic widths: squares, their sum, quotient and radicands.
   localparam int SQ_W       = 24;
   localparam int SUM_W      = 25;
   localparam int DIV_Q_W    = 29;
   localparam int MAG_RAD_W  = 34;
   localparam int DIR_RAD_W  = 30;
   localparam int DIR_ROOT_W = DIR_RAD_W / 2;
   localparam int MAG_LAT    = MAG_RAD_W / 2;
   localparam int DIR_LAT    = DIV_Q_W + DIR_RAD_W / 2;
   localparam int DIR_ONE    = 16384;

   // One column of the window: oldest row on top, newest pixel at the bottom.
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } column_type;

   // Neighbourhoods issued for one input pixel, in delivery order.
   typedef enum logic [1:0] {
      JOB_CENTRE = 2'd0,
      JOB_BOTTOM = 2'd1,
      JOB_EDGE   = 2'd2,
      JOB_CORNER = 2'd3
   } job_type;

   // Per-result data carried alongside the divider and root pipelines.
   typedef struct packed {
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic                     last;
      logic                     zero;
   } sideband_type;

endpackage

`default_nettype wire

### rtl/scgd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module scgd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/scgd_sqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
`default_nettype none

module scgd_sqrt_pipe #(
   parameter int IN_W = 34
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [IN_W-1:0]   radicand,
   output logic      [IN_W/2-1:0] root
);

   localparam int R_W = IN_W / 2;
   localparam int RW  = R_W + 3;

   logic [RW-1:0]   rem_ff  [R_W];
   logic [R_W-1:0]  root_ff [R_W];
   logic [IN_W-1:0] rad_ff  [R_W];

   for (genvar k = 0; k < R_W; k++) begin : g_stage
      logic [RW-1:0]   rem_p;
      logic [R_W-1:0]  root_p;
      logic [IN_W-1:0] rad_p;
      logic [RW-1:0]   rem_sh;
      logic [RW-1:0]   trial;
      logic            fits;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = radicand;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rad_p  = rad_ff[k-1];
      end

      // Bring down the next two radicand bits and try the next root bit.
      assign rem_sh = {rem_p[R_W:0], rad_p[IN_W-1 -: 2]};
      assign trial  = {1'b0, root_p, 2'b01};
      assign fits   = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= fits ? (rem_sh - trial) : rem_sh;
            root_ff[k] <= {root_p[R_W-2:0], fits};
            rad_ff[k]  <= {rad_p[IN_W-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[R_W-1];

endmodule

`default_nettype wire

### rtl/scgd_div_pipe.sv
// Pipelined restoring divider for a numerator not above the divisor.
`default_nettype none

module scgd_div_pipe #(
   parameter int Q_W = 29,
   parameter int D_W = 25
) (
   input  wire logic           clock,
   input  wire logic           en,
   input  wire logic [D_W-1:0] numer,
   input  wire logic [D_W-1:0] denom,
   output logic      [Q_W-1:0] quot
);

   logic [D_W-1:0] rem_ff [Q_W];
   logic [D_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0] q_ff   [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic [D_W-1:0] rem_p;
      logic [D_W-1:0] den_p;
      logic [Q_W-1:0] q_p;
      logic [D_W:0]   t;
      logic [D_W:0]   diff;
      logic           ge;

      // The first stage gives the integer bit, later ones shift the remainder.
      if (k == 0) begin : g_first
         assign rem_p = numer;
         assign den_p = denom;
         assign q_p   = '0;
         assign t     = {1'b0, rem_p};
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign den_p = den_ff[k-1];
         assign q_p   = q_ff[k-1];
         assign t     = {rem_p, 1'b0};
      end

      assign diff = t - {1'b0, den_p};
      assign ge   = (t >= {1'b0, den_p});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[D_W-1:0] : t[D_W-1:0];
            den_ff[k] <= den_p;
            q_ff[k]   <= {q_p[Q_W-2:0], ge};
         end
      end
   end

   assign quot = q_ff[Q_W-1];

endmodule

`default_nettype wire

### rtl/scharr_gradient_direction.sv
// Top level: Scharr 3x3 gradient, magnitude and unit direction over a pixel stream.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_pixel
//   rsp      out  rsp_valid/rsp_stall  grad_x, grad_y, magnitude, dir_x, dir_y, frame_last
//   csr      in   csr_valid/csr_ready  csr_index, csr_data
//
// One pixel is taken each cycle while the result channel is not stalled; a pixel that owes two
// or four results (last column, last row, final corner) holds the input while they are issued.
// Each result passes the kernel, square and sum stages, then the divider and root pipes.
// Any stalled result beat freezes the whole pipeline and nothing is lost.
// Reset is synchronous and needs no clearing pass; line store words read unwritten go unused.
`default_nettype none

module scharr_gradient_direction
   import scgd_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [PIX_W-1:0]         req_pixel,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [GRAD_W-1:0]      rsp_grad_x,
   output logic signed [GRAD_W-1:0]      rsp_grad_y,
   output logic        [MAG_W-1:0]       rsp_magnitude,
   output logic signed [DIR_W-1:0]       rsp_dir_x,
   output logic signed [DIR_W-1:0]       rsp_dir_y,
   output logic                          rsp_frame_last,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WSEL_W  = CFG_WIDTH_W + 2;
   localparam int MD_LEN  = DIR_LAT - MAG_LAT;
   localparam logic [1:0] ROW_TOP = 2'd0;
   localparam logic [1:0] ROW_MID = 2'd1;
   localparam logic [1:0] ROW_BOT = 2'd2;

   logic adv;
   logic accept;

   logic [CFG_WIDTH_W-1:0]  cfg_width_ff;
   logic [CFG_HEIGHT_W-1:0] cfg_height_ff;
   logic [WSEL_W-1:0]       wsel;
   logic [CFG_HEIGHT_W-1:0] hsel;
   logic [COL_W-1:0]        last_col;
   logic [ROW_W-1:0]        last_row;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             b_valid_ff;
   logic [PIX_W-1:0] b_pixel_ff;
   logic [COL_W-1:0] b_col_ff;
   logic             b_emit_ff, b_lastrow_ff, b_lastcol_ff, b_rtop_ff, b_cone_ff;
   job_type          job_ff, job_in;
   logic             b_done;

   logic [2*PIX_W-1:0] ram_rdata;
   column_type         cur_col, w0_ff, w1_ff;

   column_type lft, mid, rgt;
   logic [1:0] r0, r1, r2;
   logic [PIX_W-1:0] n00, n01, n02, n10, n11, n12, n20, n21, n22;
   logic signed [PIX_W:0]  dx0, dx1, dx2, dy0, dy1, dy2;
   logic signed [GRAD_W:0] gx_w, gy_w;

   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic signed [GRAD_W-1:0] s1_gx_ff, s1_gy_ff, s2_gx_ff, s2_gy_ff, s3_gx_ff, s3_gy_ff;
   logic                     s1_last_ff, s2_last_ff, s3_last_ff;
   logic signed [2*GRAD_W-1:0] gx_prod, gy_prod;
   logic [SQ_W-1:0]          s2_gxsq_ff, s2_gysq_ff, s3_gxsq_ff, s3_gysq_ff;
   logic [SUM_W-1:0]         s3_sum_ff;

   logic [DIV_Q_W-1:0]    quot_x, quot_y;
   logic [DIR_ROOT_W-1:0] root_x, root_y;
   logic [MAG_W-1:0]      mag_root;

   sideband_type     sb_ff [DIR_LAT];
   logic             v_ff  [DIR_LAT];
   logic [MAG_W-1:0] md_ff [MD_LEN];

   logic                     rsp_valid_ff;
   logic signed [GRAD_W-1:0] rsp_gx_ff, rsp_gy_ff;
   logic [MAG_W-1:0]         rsp_mag_ff;
   logic signed [DIR_W-1:0]  rsp_dx_ff, rsp_dy_ff;
   logic                     rsp_last_ff;

   function automatic logic [PIX_W-1:0] pick(input column_type col, input logic [1:0] row);
      logic [PIX_W-1:0] v;
      case (row)
         ROW_TOP: v = col.top;
         ROW_MID: v = col.mid;
         default: v = col.bot;
      endcase
      return v;
   endfunction

   function automatic logic [DIR_W-1:0] signed_dir(input logic neg, input logic zero,
                                                   input logic [DIR_ROOT_W-1:0] root);
      logic [DIR_W-1:0] m;
      m = DIR_W'(root);
      return zero ? '0 : (neg ? (~m + 1'b1) : m);
   endfunction

   // The pipeline moves whenever the result register is free or being taken.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(adv && (!b_valid_ff || b_done));
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Frame geometry, saturated into its legal range.
   always_comb begin
      if (cfg_width_ff < CFG_WIDTH_W'(3)) begin
         wsel = WSEL_W'(3);
      end else if ({2'b00, cfg_width_ff} > WSEL_W'(MAX_WIDTH)) begin
         wsel = WSEL_W'(MAX_WIDTH);
      end else begin
         wsel = {2'b00, cfg_width_ff};
      end
      if (cfg_height_ff < CFG_HEIGHT_W'(3)) begin
         hsel = CFG_HEIGHT_W'(3);
      end else if (cfg_height_ff > CFG_HEIGHT_W'(HEIGHT_CAP)) begin
         hsel = CFG_HEIGHT_W'(HEIGHT_CAP);
      end else begin
         hsel = cfg_height_ff;
      end
      last_col = COL_W'(wsel - WSEL_W'(1));
      last_row = ROW_W'(hsel - CFG_HEIGHT_W'(1));
   end

   // Raster position of the next pixel.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (col_ff == last_col) begin
         col_in = '0;
         row_in = (row_ff == last_row) ? '0 : row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
      end
   end

   // Configuration registers and frame position.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= CFG_WIDTH_W'(WIDTH_RESET);
         cfg_height_ff <= CFG_HEIGHT_W'(HEIGHT_RESET);
         col_ff        <= '0;
         row_ff        <= '0;
      end else if (csr_valid && (csr_index == CSR_IMAGE_WIDTH)) begin
         cfg_width_ff <= csr_data[CFG_WIDTH_W-1:0];
         col_ff       <= '0;
         row_ff       <= '0;
      end else if (csr_valid && (csr_index == CSR_IMAGE_HEIGHT)) begin
         cfg_height_ff <= csr_data[CFG_HEIGHT_W-1:0];
         col_ff        <= '0;
         row_ff        <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line stores: upper byte is two rows back, lower byte one row back.
   scgd_ram #(
      .WIDTH (2*PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (adv && b_valid_ff && b_done),
      .wr_addr (b_col_ff),
      .wr_data ({ram_rdata[PIX_W-1:0], b_pixel_ff}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rdata)
   );

   assign cur_col = '{top: ram_rdata[2*PIX_W-1:PIX_W], mid: ram_rdata[PIX_W-1:0],
                      bot: b_pixel_ff};

   // Next neighbourhood to issue for the pixel held in the expansion stage.
   always_comb begin
      job_in = job_ff;
      b_done = 1'b1;
      unique case (job_ff)
         JOB_CENTRE: begin
            if (b_emit_ff && b_lastrow_ff) begin
               job_in = JOB_BOTTOM;
               b_done = 1'b0;
            end else if (b_emit_ff && b_lastcol_ff) begin
               job_in = JOB_EDGE;
               b_done = 1'b0;
            end
         end
         JOB_BOTTOM: begin
            if (b_lastcol_ff) begin
               job_in = JOB_EDGE;
               b_done = 1'b0;
            end
         end
         JOB_EDGE: begin
            if (b_lastrow_ff) begin
               job_in = JOB_CORNER;
               b_done = 1'b0;
            end
         end
         JOB_CORNER: begin
            b_done = 1'b1;
         end
         default: begin
            b_done = 1'b1;
         end
      endcase
   end

   // Expansion stage: holds one pixel while its results are issued.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         job_ff     <= JOB_CENTRE;
      end else if (accept) begin
         b_valid_ff <= 1'b1;
         job_ff     <= JOB_CENTRE;
      end else if (adv && b_valid_ff) begin
         if (b_done) begin
            b_valid_ff <= 1'b0;
         end else begin
            job_ff <= job_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_pixel_ff   <= req_pixel;
         b_col_ff     <= col_ff;
         b_emit_ff    <= (row_ff != '0) && (col_ff != '0);
         b_lastrow_ff <= (row_ff == last_row);
         b_lastcol_ff <= (col_ff == last_col);
         b_rtop_ff    <= (row_ff == ROW_W'(1));
         b_cone_ff    <= (col_ff == COL_W'(1));
      end
      if (adv && b_valid_ff && b_done) begin
         w0_ff <= w1_ff;
         w1_ff <= cur_col;
      end
   end

   // Neighbourhood selection with reflected borders, then both kernels.
   always_comb begin
      if ((job_ff == JOB_EDGE) || (job_ff == JOB_CORNER)) begin
         lft = w1_ff;
         mid = cur_col;
         rgt = w1_ff;
      end else begin
         lft = b_cone_ff ? cur_col : w0_ff;
         mid = w1_ff;
         rgt = cur_col;
      end
      if ((job_ff == JOB_BOTTOM) || (job_ff == JOB_CORNER)) begin
         r0 = ROW_MID;
         r1 = ROW_BOT;
         r2 = ROW_MID;
      end else begin
         r0 = b_rtop_ff ? ROW_BOT : ROW_TOP;
         r1 = ROW_MID;
         r2 = ROW_BOT;
      end
      n00 = pick(lft, r0);  n01 = pick(mid, r0);  n02 = pick(rgt, r0);
      n10 = pick(lft, r1);  n11 = pick(mid, r1);  n12 = pick(rgt, r1);
      n20 = pick(lft, r2);  n21 = pick(mid, r2);  n22 = pick(rgt, r2);
      dx0 = $signed({1'b0, n02}) - $signed({1'b0, n00});
      dx1 = $signed({1'b0, n12}) - $signed({1'b0, n10});
      dx2 = $signed({1'b0, n22}) - $signed({1'b0, n20});
      dy0 = $signed({1'b0, n20}) - $signed({1'b0, n00});
      dy1 = $signed({1'b0, n21}) - $signed({1'b0, n01});
      dy2 = $signed({1'b0, n22}) - $signed({1'b0, n02});
      gx_w = 14'sd3 * 14'(dx0) + 14'sd10 * 14'(dx1) + 14'sd3 * 14'(dx2);
      gy_w = 14'sd3 * 14'(dy0) + 14'sd10 * 14'(dy1) + 14'sd3 * 14'(dy2);
   end

   assign gx_prod = s1_gx_ff * s1_gx_ff;
   assign gy_prod = s1_gy_ff * s1_gy_ff;

   // Front arithmetic stages: kernels, squares, sum of squares.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= b_valid_ff && b_emit_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_gx_ff   <= GRAD_W'(gx_w);
         s1_gy_ff   <= GRAD_W'(gy_w);
         s1_last_ff <= (job_ff == JOB_CORNER);
         s2_gx_ff   <= s1_gx_ff;
         s2_gy_ff   <= s1_gy_ff;
         s2_last_ff <= s1_last_ff;
         s2_gxsq_ff <= SQ_W'(gx_prod);
         s2_gysq_ff <= SQ_W'(gy_prod);
         s3_gx_ff   <= s2_gx_ff;
         s3_gy_ff   <= s2_gy_ff;
         s3_last_ff <= s2_last_ff;
         s3_gxsq_ff <= s2_gxsq_ff;
         s3_gysq_ff <= s2_gysq_ff;
         s3_sum_ff  <= SUM_W'(s2_gxsq_ff) + SUM_W'(s2_gysq_ff);
      end
   end

   // Magnitude: root of the sum of squares scaled by 256.
   scgd_sqrt_pipe #(.IN_W (MAG_RAD_W)) u_mag_sqrt (
      .clock    (clock),
      .en       (adv),
      .radicand ({1'b0, s3_sum_ff, 8'h00}),
      .root     (mag_root)
   );

   // Unit direction: root of the squared component over the sum, in Q1.14.
   scgd_div_pipe #(.Q_W (DIV_Q_W), .D_W (SUM_W)) u_div_x (
      .clock (clock),
      .en    (adv),
      .numer (SUM_W'(s3_gxsq_ff)),
      .denom (s3_sum_ff),
      .quot  (quot_x)
   );

   scgd_div_pipe #(.Q_W (DIV_Q_W), .D_W (SUM_W)) u_div_y (
      .clock (clock),
      .en    (adv),
      .numer (SUM_W'(s3_gysq_ff)),
      .denom (s3_sum_ff),
      .quot  (quot_y)
   );

   scgd_sqrt_pipe #(.IN_W (DIR_RAD_W)) u_dir_sqrt_x (
      .clock    (clock),
      .en       (adv),
      .radicand (DIR_RAD_W'(quot_x)),
      .root     (root_x)
   );

   scgd_sqrt_pipe #(.IN_W (DIR_RAD_W)) u_dir_sqrt_y (
      .clock    (clock),
      .en       (adv),
      .radicand (DIR_RAD_W'(quot_y)),
      .root     (root_y)
   );

   // Delay lines that keep valid bits, gradients and magnitude aligned with the roots.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIR_LAT; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= s3_valid_ff;
         for (int k = 1; k < DIR_LAT; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_ff[0] <= '{gx: s3_gx_ff, gy: s3_gy_ff, last: s3_last_ff,
                       zero: (s3_sum_ff == '0)};
         for (int k = 1; k < DIR_LAT; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
         md_ff[0] <= mag_root;
         for (int k = 1; k < MD_LEN; k++) begin
            md_ff[k] <= md_ff[k-1];
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_ff[DIR_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_gx_ff   <= sb_ff[DIR_LAT-1].gx;
         rsp_gy_ff   <= sb_ff[DIR_LAT-1].gy;
         rsp_mag_ff  <= md_ff[MD_LEN-1];
         rsp_dx_ff   <= signed_dir(sb_ff[DIR_LAT-1].gx[GRAD_W-1], sb_ff[DIR_LAT-1].zero,
                                   root_x);
         rsp_dy_ff   <= signed_dir(sb_ff[DIR_LAT-1].gy[GRAD_W-1], sb_ff[DIR_LAT-1].zero,
                                   root_y);
         rsp_last_ff <= sb_ff[DIR_LAT-1].last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_grad_x     = rsp_gx_ff;
   assign rsp_grad_y     = rsp_gy_ff;
   assign rsp_magnitude  = rsp_mag_ff;
   assign rsp_dir_x      = rsp_dx_ff;
   assign rsp_dir_y      = rsp_dy_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/scgd_checker.sv
// Port-level checker for the Scharr gradient block, bound to the top level.
`default_nettype none
`include "scharr_gradient_direction_macros.svh"

module scgd_checker
   import scgd_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic signed [GRAD_W-1:0] rsp_grad_x,
   input wire logic signed [GRAD_W-1:0] rsp_grad_y,
   input wire logic        [MAG_W-1:0]  rsp_magnitude,
   input wire logic signed [DIR_W-1:0]  rsp_dir_x,
   input wire logic signed [DIR_W-1:0]  rsp_dir_y,
   input wire logic                     rsp_frame_last
);

   // A stalled result beat stays valid with its magnitude, x direction and y gradient unchanged.
   `SCGD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_magnitude) && $stable(rsp_dir_x) && $stable(rsp_grad_y), "result beat changed while stalled")

   // A zero magnitude comes only with both gradients zero and has no direction.
   `SCGD_ASSERT_NOW(a_zero_mag, rsp_valid && (rsp_magnitude == '0), (rsp_grad_x == '0) && (rsp_grad_y == '0) && (rsp_dir_x == '0) && (rsp_dir_y == '0), "zero magnitude with a direction")

   // The frame corner is reflected on both sides, so its x derivative vanishes.
   `SCGD_ASSERT_NOW(a_corner_gx, rsp_valid && rsp_frame_last, rsp_grad_x == '0, "frame corner with non-zero x derivative")

   // Direction components stay within one unit.
   `SCGD_ASSERT_NOW(a_dir_range, rsp_valid, (rsp_dir_x <= DIR_W'(DIR_ONE)) && (rsp_dir_x >= -DIR_W'(DIR_ONE)) && (rsp_dir_y <= DIR_W'(DIR_ONE)) && (rsp_dir_y >= -DIR_W'(DIR_ONE)), "direction beyond unit length")

endmodule

bind scharr_gradient_direction scgd_checker u_scgd_checker (.*);

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the Scharr gradient, magnitude and direction block.
`timescale 1ns / 100ps
`default_nettype none

module testbench;
   import scgd_pkg::*;

   localparam int LINE_DEPTH = 2048;
   localparam int DRAIN_CYCLES = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 4'd15;

   typedef struct {
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic        [MAG_W-1:0]  mag;
      logic signed [DIR_W-1:0]  dx;
      logic signed [DIR_W-1:0]  dy;
      logic                     last;
   } gradient_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic        [PIX_W-1:0]        req_pixel = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [GRAD_W-1:0]       rsp_grad_x;
   logic signed [GRAD_W-1:0]       rsp_grad_y;
   logic        [MAG_W-1:0]        rsp_magnitude;
   logic signed [DIR_W-1:0]        rsp_dir_x;
   logic signed [DIR_W-1:0]        rsp_dir_y;
   logic                           rsp_frame_last;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic        [CSR_IDX_W-1:0]    csr_index = '0;
   logic        [CSR_DATA_W-1:0]   csr_data = '0;

   // Idling controls for the current phase, in percent per cycle.
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;

   // Predictor state: two line stores, the window, frame position and geometry.
   bit [PIX_W-1:0] older_line [LINE_DEPTH];
   bit [PIX_W-1:0] recent_line [LINE_DEPTH];
   column_type     win [3];
   int unsigned    row_pos;
   int unsigned    col_pos;
   int unsigned    cfg_width = WIDTH_RESET;
   int unsigned    cfg_height = HEIGHT_RESET;

   gradient_type pending_gradients [$];
   int unsigned error_count = 0;
   int unsigned pixels_sent = 0;
   int unsigned results_seen = 0;
   int unsigned frames_seen = 0;

   scharr_gradient_direction dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_grad_x     (rsp_grad_x),
      .rsp_grad_y     (rsp_grad_y),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_dir_x      (rsp_dir_x),
      .rsp_dir_y      (rsp_dir_y),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // A 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Random back-pressure on the result channel.
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // Integer square root, floor, digit by digit.
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned res;
      longint unsigned one;
      res = 0;
      one = 64'd1 << 62;
      while (one > v) one = one >> 2;
      while (one != 0) begin
         if (v >= res + one) begin
            v = v - (res + one);
            res = (res >> 1) + one;
         end else begin
            res = res >> 1;
         end
         one = one >> 2;
      end
      return res;
   endfunction

   // Unit direction component in Q1.14, truncated toward zero.
   function automatic logic signed [DIR_W-1:0] unit_component(input int g,
                                                              input longint unsigned s);
      longint unsigned a;
      longint unsigned q;
      if (s == 0) return '0;
      a = (g < 0) ? -g : g;
      q = floor_root(((a * a) << 28) / s);
      return (g < 0) ? -q[DIR_W-1:0] : q[DIR_W-1:0];
   endfunction

   function automatic int pixel_at(input column_type col, input int unsigned row);
      case (row)
         0: return col.top;
         1: return col.mid;
         default: return col.bot;
      endcase
   endfunction

   // Applies both Scharr kernels to the chosen columns and rows.
   function automatic gradient_type scharr_gradient(input column_type cl, input column_type cm,
                                                    input column_type cr, input int unsigned rt,
                                                    input int unsigned rm, input int unsigned rb,
                                                    input bit last);
      int n [3][3];
      column_type cols [3];
      int unsigned rows [3];
      int gx;
      int gy;
      longint unsigned s;
      gradient_type g;
      cols[0] = cl; cols[1] = cm; cols[2] = cr;
      rows[0] = rt; rows[1] = rm; rows[2] = rb;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            n[i][j] = pixel_at(cols[j], rows[i]);
      gx = 3 * (n[0][2] - n[0][0]) + 10 * (n[1][2] - n[1][0]) + 3 * (n[2][2] - n[2][0]);
      gy = 3 * (n[2][0] - n[0][0]) + 10 * (n[2][1] - n[0][1]) + 3 * (n[2][2] - n[0][2]);
      s = longint'(gx) * gx + longint'(gy) * gy;
      g.gx = gx[GRAD_W-1:0];
      g.gy = gy[GRAD_W-1:0];
      g.mag = floor_root(s * 256);
      g.dx = unit_component(gx, s);
      g.dy = unit_component(gy, s);
      g.last = last;
      return g;
   endfunction

   // Appends one expected gradient behind those already waiting.
   function automatic void enqueue_gradient(input gradient_type g);
      pending_gradients.insert(pending_gradients.size(), g);
   endfunction

   // Advances the predictor by one pixel and queues the gradients it completes.
   task automatic predict_pixel(input logic [PIX_W-1:0] p);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      int unsigned rt;
      column_type cl;
      column_type fresh;
      bit last_row;
      w = (cfg_width < 3) ? 3 : (cfg_width > LINE_DEPTH) ? LINE_DEPTH : cfg_width;
      h = (cfg_height < 3) ? 3 : (cfg_height > HEIGHT_CAP) ? HEIGHT_CAP : cfg_height;
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;
      fresh.top = older_line[c];
      fresh.mid = recent_line[c];
      fresh.bot = p;
      win[0] = win[1];
      win[1] = win[2];
      win[2] = fresh;
      older_line[c] = recent_line[c];
      recent_line[c] = p;
      last_row = (r == h - 1);
      if (r >= 1 && c >= 1) begin
         // The top row reflects onto the second when the window sits on row one.
         rt = (r == 1) ? 2 : 0;
         cl = (c == 1) ? win[2] : win[0];
         enqueue_gradient(scharr_gradient(cl, win[1], win[2], rt, 1, 2, 1'b0));
         if (last_row)
            enqueue_gradient(scharr_gradient(cl, win[1], win[2], 1, 2, 1, 1'b0));
         // The right-hand column reflects once the row's last pixel is in.
         if (c == w - 1) begin
            enqueue_gradient(scharr_gradient(win[1], win[2], win[1], rt, 1, 2, 1'b0));
            if (last_row)
               enqueue_gradient(scharr_gradient(win[1], win[2], win[1], 1, 2, 1, 1'b1));
         end
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   // Sends one pixel beat, idling first as the phase asks.
   task automatic send_pixel(input logic [PIX_W-1:0] p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pixel(p);
      pixels_sent++;
   endtask

   // Holds the input until every expected gradient has come, then lets the pipe settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_gradients.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes one register; any known index restarts the frame position.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH || idx == CSR_IMAGE_HEIGHT) begin
         if (idx == CSR_IMAGE_WIDTH) cfg_width = value & 16'h0FFF;
         else cfg_height = value & 16'h1FFF;
         row_pos = 0;
         col_pos = 0;
      end
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h);
      drain_results();
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   // Small frames of edge values: checkerboard, flat black, and single bits.
   task automatic test_directed();
      set_geometry(3, 3);
      for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'd255 : 8'd0);
      for (int i = 0; i < 9; i++) send_pixel(8'd0);
      for (int i = 0; i < 8; i++) send_pixel(8'd1 << i);
      send_pixel(8'd254);
   endtask

   // Saturated geometry at both ends, and an index that is ignored.
   task automatic test_geometry_limits();
      set_geometry(0, 0);
      write_register(CSR_UNUSED_INDEX, 16'hFFFF);
      for (int i = 0; i < 9; i++) send_pixel(random_pixel());
      set_geometry(4095, 3);
      for (int i = 0; i < 24; i++) send_pixel(random_pixel());
      set_geometry(3, 8191);
      for (int i = 0; i < 12; i++) send_pixel(random_pixel());
   endtask

   // Whole frames of random size and content under one idling pattern.
   task automatic test_random_frames(input int unsigned idle, input int unsigned stall,
                                     input int unsigned frames, input bit pause_midway);
      int unsigned w;
      int unsigned h;
      set_geometry($urandom_range(9, 3), $urandom_range(6, 3));
      send_idle_pct = idle;
      stall_pct = stall;
      for (int f = 0; f < frames; f++) begin
         w = $urandom_range(9, 3);
         h = $urandom_range(6, 3);
         set_geometry(w, h);
         for (int i = 0; i < w * h; i++) begin
            // Hold off once mid-frame until the pipe is empty.
            if (pause_midway && f == 0 && i == (w * h) / 2) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending_gradients.size() != 0) @(posedge clock);
            end
            send_pixel(random_pixel());
         end
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic check_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // Compares every result beat with the oldest expectation.
   always @(posedge clock) begin
      gradient_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_gradients.size() == 0) begin
            $display("%0t: unexpected result beat, gx %0d gy %0d", $time, rsp_grad_x,
                     rsp_grad_y);
            error_count++;
         end else begin
            e = pending_gradients.pop_front();
            check_field("grad_x", e.gx, rsp_grad_x);
            check_field("grad_y", e.gy, rsp_grad_y);
            check_field("magnitude", e.mag, rsp_magnitude);
            check_field("dir_x", e.dx, rsp_dir_x);
            check_field("dir_y", e.dy, rsp_dir_y);
            check_field("frame_last", e.last, rsp_frame_last);
            results_seen++;
            if (rsp_frame_last) frames_seen++;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_geometry_limits();
      test_random_frames(0, 0, 3, 1'b0);
      test_random_frames(84, 0, 3, 1'b1);
      test_random_frames(0, 84, 3, 1'b0);
      test_random_frames(32, 32, 3, 1'b0);
      drain_results();
      if (pending_gradients.size() != 0) error_count++;
      $display("Sent %0d pixels; checked %0d gradients across %0d complete frames,",
               pixels_sent, results_seen, frames_seen);
      $display("with saturated geometry and four idling patterns.");
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5ms;
      $display("Run timed out with %0d gradients outstanding.", pending_gradients.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
